// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cqit_pkg.sv =====
// ----------------------------------------------------------------------------
// cqit_pkg
// Constants and codes for the circular queue with indexed take.
// ----------------------------------------------------------------------------
`default_nettype none

package cqit_pkg;

    // Number of entries. Must be a power of two so that pointers wrap by
    // truncation.
    localparam int DEPTH  = 128;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // Width wide enough to compare the count against the 8-bit position.
    localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;

    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_GET  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_SHORT = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/circular_queue_with_indexed_take.sv =====
// ----------------------------------------------------------------------------
// circular_queue_with_indexed_take
// Circular FIFO of signed 32-bit words with push, pop and indexed get.
// ----------------------------------------------------------------------------
// The queue holds its words in one synchronous memory addressed from a head
// pointer and an element count. A request is decoded in the cycle it is
// accepted: the pointer and count update at once, a push writes the memory and
// a pop or get issues the one memory read it needs on the accepting edge. The
// read data is ready in the following cycle, and the result item moves from the
// pending stage into the output register once that register is empty or its
// item is taken. One request is accepted every cycle while the result side
// keeps up; the single memory read port and the one-entry stage in front of
// the output register set that figure. Entries never written are never read,
// so the memory needs no clearing after reset and the block is ready straight
// out of reset.
`default_nettype none

module circular_queue_with_indexed_take
    import cqit_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_req_type,
    input  wire logic signed [31:0] s_push_value,
    input  wire logic               s_from_back,
    input  wire logic [7:0]         s_position,
    input  wire logic               s_keep_rest,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_read_value,
    output logic [1:0]              m_status,
    output logic [7:0]              m_fill_count
);

    logic [31:0]       mem [DEPTH];
    logic [31:0]       mem_rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;

    logic [ADDR_W-1:0] head_reg,  head_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              pend_valid_reg,   pend_valid_next;
    logic              pend_use_mem_reg, pend_use_mem_next;
    logic [1:0]        pend_status_reg,  pend_status_next;
    logic [7:0]        pend_fill_reg,    pend_fill_next;

    logic              m_valid_reg,      m_valid_next;
    logic [31:0]       m_read_value_reg;
    logic [1:0]        m_status_reg;
    logic [7:0]        m_fill_count_reg;

    logic              accept;
    logic              out_load;
    logic              is_full;
    logic              get_bad;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  n_ext;
    logic [CMP_W-1:0]  back_off;
    logic [CMP_W-1:0]  fill_ext;

    assign out_load = pend_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !pend_valid_reg || out_load;
    assign accept   = s_valid && s_ready;

    assign cnt_ext  = CMP_W'(count_reg);
    assign n_ext    = CMP_W'(s_position);
    assign back_off = cnt_ext - n_ext;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign get_bad  = (s_position == 8'd0) || (n_ext > cnt_ext);

    always_comb begin
        head_next         = head_reg;
        count_next        = count_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_waddr         = head_reg + count_reg[ADDR_W-1:0];
        mem_raddr         = head_reg;
        pend_use_mem_next = 1'b0;
        pend_status_next  = STATUS_OK;

        if (accept) begin
            case (s_req_type)
                REQ_PUSH: begin
                    if (is_full) begin
                        pend_status_next = STATUS_FULL;
                    end else begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                REQ_POP: begin
                    if (count_reg == '0) begin
                        pend_status_next = STATUS_SHORT;
                    end else begin
                        mem_re            = 1'b1;
                        pend_use_mem_next = 1'b1;
                        head_next         = head_reg + ADDR_W'(1);
                        count_next        = count_reg - CNT_W'(1);
                    end
                end
                REQ_GET: begin
                    if (get_bad) begin
                        pend_status_next = STATUS_SHORT;
                    end else begin
                        mem_re            = 1'b1;
                        pend_use_mem_next = 1'b1;
                        if (!s_from_back) begin
                            mem_raddr = head_reg + n_ext[ADDR_W-1:0] - ADDR_W'(1);
                            if (!s_keep_rest) begin
                                head_next  = head_reg + n_ext[ADDR_W-1:0];
                                count_next = count_reg - n_ext[CNT_W-1:0];
                            end
                        end else begin
                            // Dropping from the tail leaves the head in place.
                            mem_raddr = head_reg + back_off[ADDR_W-1:0];
                            if (!s_keep_rest) begin
                                count_next = count_reg - n_ext[CNT_W-1:0];
                            end
                        end
                    end
                end
                default: begin
                    // The unused request code is answered without effect.
                    pend_status_next = STATUS_OK;
                end
            endcase
        end
    end

    assign fill_ext       = CMP_W'(count_next);
    assign pend_fill_next = fill_ext[7:0];

    always_comb begin
        if (accept) begin
            pend_valid_next = 1'b1;
        end else if (out_load) begin
            pend_valid_next = 1'b0;
        end else begin
            pend_valid_next = pend_valid_reg;
        end

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Entry store. The read data register only changes when a request reads,
    // so it holds while the pending item waits for the output register.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= s_push_value;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            head_reg       <= head_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_use_mem_reg <= pend_use_mem_next;
            pend_status_reg  <= pend_status_next;
            pend_fill_reg    <= pend_fill_next;
        end
        if (out_load) begin
            m_read_value_reg <= pend_use_mem_reg ? mem_rdata_reg : 32'd0;
            m_status_reg     <= pend_status_reg;
            m_fill_count_reg <= pend_fill_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;
    assign m_fill_count = m_fill_count_reg;

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH),
        "count above depth")
    `ASSERT_IMPLIES(a_err_zero, aclk, aresetn, m_valid && (m_status != STATUS_OK),
        m_read_value == 32'sd0, "error item carries a value")
    `ASSERT_IMPLIES(a_stall_block, aclk, aresetn, pend_valid_reg && m_valid && !m_ready,
        !s_ready, "item accepted while result path is stalled")
    `ASSERT_NEXT(a_push_count, aclk, aresetn, accept && (s_req_type == REQ_PUSH) && !is_full,
        count_reg == $past(count_reg) + CNT_W'(1), "push did not grow the count")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the circular queue with push, pop and indexed get.
// ----------------------------------------------------------------------------
// A list of request items is built up front: a directed opening on the empty
// and nearly empty queue, a fill past the full mark, and then a long random
// mix of pushes, pops and gets with occasional fill and drain bursts. A clocked
// driver offers them on the request channel and a clocked monitor keeps a
// shadow copy of the queue. That copy yields the expected reply for each
// accepted request, and the replies are checked field by field in order.
// Both channels idle at random. The reply side also holds off for a long
// stretch once, so that the block backs up and stalls its request side.
// ----------------------------------------------------------------------------

module tb_top
    import cqit_pkg::*;
();

    // The request code that the block ignores.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
        logic               back;
        logic [7:0]         pos;
        logic               keep;
        logic               settle;   // wait for all replies before offering
    } queue_req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic [7:0]         fill;
    } queue_reply_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_req_type = REQ_PUSH;
    logic signed [31:0] s_push_value = '0;
    logic               s_from_back = 1'b0;
    logic [7:0]         s_position = '0;
    logic               s_keep_rest = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_read_value;
    logic [1:0]         m_status;
    logic [7:0]         m_fill_count;

    circular_queue_with_indexed_take i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_push_value (s_push_value),
        .s_from_back  (s_from_back),
        .s_position   (s_position),
        .s_keep_rest  (s_keep_rest),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_fill_count (m_fill_count)
    );

    always #5 aclk = ~aclk;

    queue_req_t   request_backlog[$];
    queue_reply_t predicted_replies[$];

    // Shadow copy of the queue.
    logic signed [31:0] shadow_words [DEPTH];
    logic [ADDR_W-1:0]  shadow_head = '0;
    logic [CNT_W-1:0]   shadow_count = '0;

    logic req_taken = 1'b0;
    int   taken_count = 0;
    int   mismatches = 0;
    int   gen_count = 0;
    int   offered = 0;
    logic hold_for_drain = 1'b0;
    logic calm;

    // No random idling on either side over this stretch of requests.
    assign calm = (taken_count >= 600) && (taken_count < 750);

    function automatic queue_reply_t apply_to_shadow_queue(queue_req_t rq);
        queue_reply_t      r;
        logic [ADDR_W-1:0] idx;
        r.value  = '0;
        r.status = STATUS_OK;
        case (rq.kind)
            REQ_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    idx = ADDR_W'(shadow_head + shadow_count);
                    shadow_words[idx] = rq.value;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            REQ_POP: begin
                if (shadow_count == 0) begin
                    r.status = STATUS_SHORT;
                end else begin
                    r.value = shadow_words[shadow_head];
                    shadow_head = shadow_head + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                end
            end
            REQ_GET: begin
                if (rq.pos == 0 || rq.pos > shadow_count) begin
                    r.status = STATUS_SHORT;
                end else if (!rq.back) begin
                    idx = ADDR_W'(shadow_head + rq.pos - 1'b1);
                    r.value = shadow_words[idx];
                    if (!rq.keep) begin
                        shadow_head = ADDR_W'(shadow_head + rq.pos);
                        shadow_count = shadow_count - rq.pos;
                    end
                end else begin
                    // Dropping from the tail only shortens the queue.
                    idx = ADDR_W'(shadow_head + (shadow_count - rq.pos));
                    r.value = shadow_words[idx];
                    if (!rq.keep) begin
                        shadow_count = shadow_count - rq.pos;
                    end
                end
            end
            default: begin
            end
        endcase
        r.fill = shadow_count;
        return r;
    endfunction

    task automatic offer(input logic [1:0] kind, input logic [31:0] value,
                         input logic back, input logic [7:0] pos, input logic keep);
        queue_req_t rq;
        rq = '{kind, value, back, pos, keep, hold_for_drain};
        case (kind)
            REQ_PUSH: if (gen_count < DEPTH) gen_count++;
            REQ_POP:  if (gen_count != 0) gen_count--;
            REQ_GET:  if (pos != 0 && pos <= gen_count && !keep) gen_count -= pos;
            default: begin
            end
        endcase
        request_backlog.push_back(rq);
        offered++;
        hold_for_drain = 1'b0;
    endtask

    // Request driver.
    always @(negedge aclk) begin : drive_requests
        queue_req_t nxt;
        if (aresetn && (!s_valid || req_taken)) begin
            if (request_backlog.size() != 0
                    && !(request_backlog[0].settle && predicted_replies.size() != 0)
                    && (calm || $urandom_range(0, 99) >= 21)) begin
                nxt = request_backlog.pop_front();
                s_valid      <= 1'b1;
                s_req_type   <= nxt.kind;
                s_push_value <= nxt.value;
                s_from_back  <= nxt.back;
                s_position   <= nxt.pos;
                s_keep_rest  <= nxt.keep;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Reply side: random back-pressure plus one long hold-off.
    always @(negedge aclk) begin : drive_reply_ready
        int   stall_left;
        logic stall_done;
        if (!aresetn) begin
            stall_left = 0;
            stall_done = 1'b0;
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (taken_count >= 200 && !stall_done) begin
            stall_done = 1'b1;
            stall_left = 150;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 21);
        end
    end

    // Monitor: predict on each accepted request, check each accepted reply.
    always @(posedge aclk) begin : watch_channels
        queue_req_t   rq;
        queue_reply_t want;
        if (!aresetn) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (predicted_replies.size() == 0) begin
                    $display("%0t: reply with none expected: value %0d status %0d fill %0d",
                             $time, m_read_value, m_status, m_fill_count);
                    mismatches++;
                end else begin
                    want = predicted_replies.pop_front();
                    if (m_read_value !== want.value) begin
                        $display("%0t: read_value expected %0d, got %0d",
                                 $time, want.value, m_read_value);
                        mismatches++;
                    end
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, m_status);
                        mismatches++;
                    end
                    if (m_fill_count !== want.fill) begin
                        $display("%0t: fill_count expected %0d, got %0d",
                                 $time, want.fill, m_fill_count);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                rq = '{s_req_type, s_push_value, s_from_back, s_position, s_keep_rest, 1'b0};
                predicted_replies.push_back(apply_to_shadow_queue(rq));
                taken_count++;
            end
        end
    end

    initial begin : stimulus
        int unsigned pick;
        int unsigned top;
        logic        mid_drain_done;
        mid_drain_done = 1'b0;

        // Empty queue, ignored request code and the value extremes.
        offer(REQ_POP, 0, 1'b0, 8'd0, 1'b0);
        offer(REQ_GET, 0, 1'b0, 8'd1, 1'b1);
        offer(REQ_UNUSED, 32'hffff_ffff, 1'b1, 8'd255, 1'b1);
        offer(REQ_PUSH, 32'h7fff_ffff, 1'b0, 8'd0, 1'b0);
        offer(REQ_PUSH, 32'h8000_0000, 1'b0, 8'd0, 1'b0);
        offer(REQ_PUSH, 32'h0000_0000, 1'b0, 8'd0, 1'b0);
        offer(REQ_PUSH, 32'hffff_ffff, 1'b0, 8'd0, 1'b0);
        offer(REQ_PUSH, 32'h5a5a_5a5a, 1'b0, 8'd0, 1'b0);
        // Positions of zero and above the count.
        offer(REQ_GET, 0, 1'b0, 8'd0, 1'b1);
        offer(REQ_GET, 0, 1'b0, 8'd6, 1'b1);
        offer(REQ_GET, 0, 1'b1, 8'd255, 1'b0);
        // Gets that keep the queue, from either end.
        offer(REQ_GET, 0, 1'b0, 8'd5, 1'b1);
        offer(REQ_GET, 0, 1'b1, 8'd1, 1'b1);
        offer(REQ_GET, 0, 1'b1, 8'd5, 1'b1);
        offer(REQ_GET, 0, 1'b0, 8'd1, 1'b1);
        offer(REQ_POP, 0, 1'b0, 8'd0, 1'b0);
        // Gets that drop items from the tail and from the head.
        offer(REQ_GET, 0, 1'b1, 8'd1, 1'b0);
        offer(REQ_GET, 0, 1'b0, 8'd2, 1'b0);
        offer(REQ_PUSH, 32'd1, 1'b0, 8'd0, 1'b0);
        offer(REQ_PUSH, 32'd2, 1'b0, 8'd0, 1'b0);
        offer(REQ_GET, 0, 1'b1, 8'd3, 1'b0);
        offer(REQ_POP, 0, 1'b0, 8'd0, 1'b0);
        offer(REQ_PUSH, 32'h0000_00ff, 1'b0, 8'd0, 1'b0);
        offer(REQ_GET, 0, 1'b0, 8'd1, 1'b0);

        // Fill to the brim and push once more.
        hold_for_drain = 1'b1;
        while (gen_count < DEPTH) offer(REQ_PUSH, $urandom, 1'b0, 8'd0, 1'b0);
        offer(REQ_PUSH, $urandom, 1'b0, 8'd0, 1'b0);
        offer(REQ_GET, 0, 1'b0, 8'd128, 1'b1);
        offer(REQ_GET, 0, 1'b1, 8'd128, 1'b1);
        offer(REQ_GET, 0, 1'b0, 8'd129, 1'b1);

        while (offered < 900) begin
            if (offered >= 450 && !mid_drain_done) begin
                hold_for_drain = 1'b1;
                mid_drain_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            top = (gen_count == 0) ? 1 : gen_count;
            if (pick < 1) begin
                while (gen_count < DEPTH) offer(REQ_PUSH, $urandom, 1'b0, 8'd0, 1'b0);
                offer(REQ_PUSH, $urandom, 1'b0, 8'd0, 1'b0);
            end else if (pick < 2) begin
                while (gen_count != 0) offer(REQ_POP, $urandom, 1'b0, 8'd0, 1'b0);
                offer(REQ_POP, $urandom, 1'b0, 8'd0, 1'b0);
            end else if (pick < 5) begin
                offer(REQ_UNUSED, $urandom, 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else if (pick < 48) begin
                offer(REQ_PUSH, $urandom, 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else if (pick < 63) begin
                offer(REQ_POP, $urandom, 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                pick = $urandom_range(0, 9);
                offer(REQ_GET, $urandom, 1'($urandom_range(0, 1)),
                      (pick < 8) ? 8'($urandom_range(1, top)) :
                      (pick == 8) ? 8'(gen_count + 1) : 8'($urandom_range(0, 255)),
                      $urandom_range(0, 3) != 0);
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (request_backlog.size() != 0 || s_valid) @(posedge aclk);
        while (predicted_replies.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && predicted_replies.size() == 0) begin
            $display("** circular_queue_with_indexed_take: PASSED **");
        end else begin
            $display("** circular_queue_with_indexed_take: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("** circular_queue_with_indexed_take: FAILED **");
        $finish;
    end

endmodule
